// File: rtl/e2q_pkg.sv
// Package for the Euler to quaternion block: constants, CORDIC arctangent table.
// No dependencies.
`default_nettype none
package e2q_pkg;
    localparam int ANGLE_WIDTH_D   = 24;
    localparam int OUT_WIDTH_D     = 16;
    localparam int CORDIC_STAGES_D = 16;
    localparam int CW              = 34;   // CORDIC x/y width, Q2.30 plus guard
    localparam int ZW              = 33;   // binary angle width plus sign
    localparam logic [31:0] MUL_RAD  = 32'd2734261102;
    localparam logic [31:0] MUL_DEG  = 32'd47721859;
    localparam logic [CW-1:0] GAIN_Q30 = CW'(652032874);

    typedef enum logic {UNIT_RAD = 1'b0, UNIT_DEG = 1'b1} t_unit;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t [32];
        t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
              32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
              32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
              32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
              32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
              32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        return t[i[4:0]];
    endfunction
endpackage
`default_nettype wire

// File: rtl/e2q_cell.sv
// One CORDIC rotation cell: a registered micro-rotation for three angles.
// Depends on e2q_pkg.
`default_nettype none
module e2q_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [3*e2q_pkg::CW-1:0] i_x,
    input  wire logic [3*e2q_pkg::CW-1:0] i_y,
    input  wire logic [3*e2q_pkg::ZW-1:0] i_z,
    input  wire logic [2:0]             i_neg,
    output logic [3*e2q_pkg::CW-1:0]     o_x,
    output logic [3*e2q_pkg::CW-1:0]     o_y,
    output logic [3*e2q_pkg::ZW-1:0]     o_z,
    output logic [2:0]                   o_neg
);
    import e2q_pkg::*;
    localparam logic signed [ZW-1:0] ATN = ZW'(atan_turn(STAGE));
    logic [3*CW-1:0] n_x, n_y;
    logic [3*ZW-1:0] n_z;

    // Rotate each lane toward zero residual angle.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [CW-1:0] x, y;
            logic signed [ZW-1:0] z;
            x = i_x[k*CW +: CW];
            y = i_y[k*CW +: CW];
            z = i_z[k*ZW +: ZW];
            if (!z[ZW-1]) begin
                n_x[k*CW +: CW] = x - (y >>> STAGE);
                n_y[k*CW +: CW] = y + (x >>> STAGE);
                n_z[k*ZW +: ZW] = z - ATN;
            end else begin
                n_x[k*CW +: CW] = x + (y >>> STAGE);
                n_y[k*CW +: CW] = y - (x >>> STAGE);
                n_z[k*ZW +: ZW] = z + ATN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_x;
            o_y <= n_y;
            o_z <= n_z;
            o_neg <= i_neg;
        end
    end
endmodule
`default_nettype wire

// File: rtl/e2q_combine.sv
// Quaternion product stages: pair products, triple products, sums, round, saturate.
// Depends on e2q_pkg.
`default_nettype none
module e2q_combine #(
    parameter int OUT_WIDTH = e2q_pkg::OUT_WIDTH_D
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [3*e2q_pkg::CW-1:0] i_c,  // cr, cp, cy lanes
    input  wire logic [3*e2q_pkg::CW-1:0] i_s,  // sr, sp, sy lanes
    output logic [4*OUT_WIDTH-1:0]     o_q     // w, x, y, z
);
    import e2q_pkg::*;
    localparam int SH = 61 - OUT_WIDTH;
    localparam int PW = 2*CW;
    typedef logic signed [CW-1:0] t_v;

    t_v cr, cp, cy, sr, sp, sy;
    // Stage 1: pair products floored to Q30, with partner factors delayed.
    t_v r_p [8];
    t_v r_f [8];
    // Stage 2: triple products at Q60.
    logic signed [PW-1:0] r_t [8];
    // Stage 3: signed sums.
    logic signed [PW:0] r_sum [4];

    assign cr = i_c[0*CW +: CW];  assign cp = i_c[1*CW +: CW];  assign cy = i_c[2*CW +: CW];
    assign sr = i_s[0*CW +: CW];  assign sp = i_s[1*CW +: CW];  assign sy = i_s[2*CW +: CW];

    function automatic t_v mq(input t_v a, input t_v b);
        logic signed [PW-1:0] p;
        p = a * b;
        return t_v'(p >>> 30);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= mq(cr, cp); r_f[0] <= cy;
            r_p[1] <= mq(sr, sp); r_f[1] <= sy;
            r_p[2] <= mq(sr, cp); r_f[2] <= cy;
            r_p[3] <= mq(cr, sp); r_f[3] <= sy;
            r_p[4] <= mq(cr, sp); r_f[4] <= cy;
            r_p[5] <= mq(sr, cp); r_f[5] <= sy;
            r_p[6] <= mq(cr, cp); r_f[6] <= sy;
            r_p[7] <= mq(sr, sp); r_f[7] <= cy;
            for (int k = 0; k < 8; k++) r_t[k] <= r_p[k] * r_f[k];
            r_sum[0] <= (PW+1)'(r_t[0]) + (PW+1)'(r_t[1]);
            r_sum[1] <= (PW+1)'(r_t[2]) - (PW+1)'(r_t[3]);
            r_sum[2] <= (PW+1)'(r_t[4]) + (PW+1)'(r_t[5]);
            r_sum[3] <= (PW+1)'(r_t[6]) - (PW+1)'(r_t[7]);
        end
    end

    // Round half up and saturate into the output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                logic signed [PW:0] r;
                r = (r_sum[k] + ((PW+1)'(1) <<< (SH-1))) >>> SH;
                if (r > (PW+1)'((64'sd1 <<< (OUT_WIDTH-1)) - 1))
                    o_q[k*OUT_WIDTH +: OUT_WIDTH] <= {1'b0, {(OUT_WIDTH-1){1'b1}}};
                else if (r < -((PW+1)'(1) <<< (OUT_WIDTH-1)))
                    o_q[k*OUT_WIDTH +: OUT_WIDTH] <= {1'b1, {(OUT_WIDTH-1){1'b0}}};
                else
                    o_q[k*OUT_WIDTH +: OUT_WIDTH] <= r[OUT_WIDTH-1:0];
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/euler_to_quaternion.sv
// Top level of the Euler to quaternion block: angle scaling, CORDIC cell chain,
// quaternion product stages. Depends on e2q_pkg, e2q_cell and e2q_combine.
//
// Usage: input beats on s_axis carry roll, pitch and yaw (Q10.13); output beats
// on m_axis carry w, x, y, z (Q1.15 at default width). The block is a fixed
// pipeline: the scale stage, one cell per CORDIC stage, the sign fix stage, two
// product stages, a sum stage and the round/saturate register. One beat is
// taken every cycle unless the receiver stalls. The whole pipeline advances
// together; when the receiver stalls with the output beat full, the pipeline
// freezes and s_axis_tready falls, so no beat is lost. Bubbles travel as
// cleared valid bits. Reset clears all valid bits and the angle_unit register
// (radians). Write i_cfg_we/i_cfg_data only while idle.
`default_nettype none
module euler_to_quaternion #(
    parameter int ANGLE_WIDTH   = e2q_pkg::ANGLE_WIDTH_D,
    parameter int OUT_WIDTH     = e2q_pkg::OUT_WIDTH_D,
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_D
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_data,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle from bit 0 up
    input  wire logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up
    output logic [((4*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
    import e2q_pkg::*;
    localparam int DEPTH = CORDIC_STAGES + 6;
    localparam int PROW  = ANGLE_WIDTH + 32;

    logic r_unit;
    logic [DEPTH-1:0] r_vld;
    logic en;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_RAD;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) r_unit <= i_cfg_data;
            if (en) r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // Scale stage: binary half angle, folded into the CORDIC range.
    logic [3*CW-1:0] x_c [CORDIC_STAGES+1];
    logic [3*CW-1:0] y_c [CORDIC_STAGES+1];
    logic [3*ZW-1:0] z_c [CORDIC_STAGES+1];
    logic [2:0]      g_c [CORDIC_STAGES+1];
    logic [3*ZW-1:0] r_z0;
    logic [2:0]      r_g0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [PROW-1:0] p;
                logic [31:0] h;
                p = $signed(s_axis_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH])
                    * $signed({1'b0, (r_unit == UNIT_DEG) ? MUL_DEG : MUL_RAD});
                h = p[47:16];
                r_g0[k] <= h[31] ^ h[30];
                if (h[31] ^ h[30]) h = h + 32'h8000_0000;
                r_z0[k*ZW +: ZW] <= {h[31], h};
            end
        end
    end

    // Every lane starts at the gain-corrected unit vector.
    assign x_c[0] = {3{GAIN_Q30}};
    assign y_c[0] = '0;
    assign z_c[0] = r_z0;
    assign g_c[0] = r_g0;

    // Chain of rotation cells.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        e2q_cell #(.STAGE(i)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_x(x_c[i]), .i_y(y_c[i]), .i_z(z_c[i]), .i_neg(g_c[i]),
            .o_x(x_c[i+1]), .o_y(y_c[i+1]), .o_z(z_c[i+1]), .o_neg(g_c[i+1])
        );
    end

    // Undo the fold by negating cosine and sine.
    logic [3*CW-1:0] r_c, r_s;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k*CW +: CW] <= g_c[CORDIC_STAGES][k] ?
                    -x_c[CORDIC_STAGES][k*CW +: CW] : x_c[CORDIC_STAGES][k*CW +: CW];
                r_s[k*CW +: CW] <= g_c[CORDIC_STAGES][k] ?
                    -y_c[CORDIC_STAGES][k*CW +: CW] : y_c[CORDIC_STAGES][k*CW +: CW];
            end
        end
    end

    logic [4*OUT_WIDTH-1:0] q;
    e2q_combine #(.OUT_WIDTH(OUT_WIDTH)) u_comb (
        .i_clk(i_clk), .i_en(en), .i_c(r_c), .i_s(r_s), .o_q(q)
    );
    assign m_axis_tdata = {{(((4*OUT_WIDTH+7)/8)*8 - 4*OUT_WIDTH){1'b0}}, q};

    // A stalled output beat holds its place; an accepted beat is the only exit.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vld[DEPTH-2:0]))
        else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// File: tb/sv/e2q_checker.sv
// Checker for the Euler to quaternion block: watches both streams, predicts each
// quaternion from the input angles and compares it. Depends on e2q_pkg (t_unit).
`timescale 1ns / 1ps
module e2q_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [71:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [63:0] i_m_tdata,
    output int               o_errors,
    output int               o_pending
);
    import e2q_pkg::*;

    typedef struct packed {
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
        logic [15:0] w;
    } t_quat;

    localparam longint GAIN = 64'sd652032874;

    // Arctangent of 2^-i in binary-angle units (2^32 per turn).
    longint atan_units [16] = '{536870912, 316933406, 167458907, 85004756,
                                42667331, 21354465, 10679838, 5340245,
                                2670163, 1335087, 667544, 333772, 166886,
                                83443, 41722, 20861};

    t_unit unit_sel;
    t_quat quat_fifo [$];
    int    beats_seen;

    // Cosine and sine of half the angle, Q30.
    function automatic void half_sin_cos(input logic [23:0] ang, output longint c,
                                         output longint s);
        longint a, p, x, y, z, dx, dy;
        logic [31:0] h;
        bit flip;
        a = longint'($signed(ang));
        p = a * ((unit_sel == UNIT_DEG) ? 64'sd47721859 : 64'sd2734261102);
        h = p[47:16];
        flip = (h[31:30] == 2'd1) || (h[31:30] == 2'd2);
        if (flip) h = h + 32'h8000_0000;
        z = longint'($signed(h));
        x = GAIN;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_units[i];
            end else begin
                x += dx; y -= dy; z += atan_units[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint prod3(longint a, longint b, longint c);
        return ((a * b) >>> 30) * c;
    endfunction

    // Round a Q60 sum half up to Q15 and saturate.
    function automatic logic [15:0] round_sat(longint q60);
        longint r;
        r = (q60 + (64'sd1 <<< 44)) >>> 45;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic t_quat predict_quat(logic [71:0] d);
        longint cr, sr, cp, sp, cy, sy;
        t_quat q;
        half_sin_cos(d[23:0], cr, sr);
        half_sin_cos(d[47:24], cp, sp);
        half_sin_cos(d[71:48], cy, sy);
        q.w = round_sat(prod3(cr, cp, cy) + prod3(sr, sp, sy));
        q.x = round_sat(prod3(sr, cp, cy) - prod3(cr, sp, sy));
        q.y = round_sat(prod3(cr, sp, cy) + prod3(sr, cp, sy));
        q.z = round_sat(prod3(cr, cp, sy) - prod3(sr, sp, cy));
        return q;
    endfunction

    assign o_pending = quat_fifo.size();

    // Predict on each accepted input beat, compare on each accepted output beat.
    always @(posedge i_clk) begin
        t_quat exp_q, got_q;
        if (!i_rst_n) begin
            unit_sel <= UNIT_RAD;
            o_errors <= 0;
            beats_seen <= 0;
        end else begin
            if (i_cfg_we) unit_sel <= t_unit'(i_cfg_data);
            if (i_s_tvalid && i_s_tready) quat_fifo.push_back(predict_quat(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got_q = i_m_tdata;
                beats_seen <= beats_seen + 1;
                if (quat_fifo.size() == 0) begin
                    $display("%0t: unexpected output beat, expected none, actual %h",
                             $time, got_q);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_q = quat_fifo.pop_front();
                    if (got_q.w !== exp_q.w || got_q.x !== exp_q.x ||
                        got_q.y !== exp_q.y || got_q.z !== exp_q.z) begin
                        $display("%0t: mismatch, expected w=%h x=%h y=%h z=%h, actual w=%h x=%h y=%h z=%h",
                                 $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z,
                                 got_q.w, got_q.x, got_q.y, got_q.z);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the Euler to quaternion block: clock, reset, stimulus, verdict.
// Depends on e2q_pkg, euler_to_quaternion and e2q_checker.
`timescale 1ns / 1ps
module tb_top;
    import e2q_pkg::*;

    localparam int RUN_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          sent = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;

    always #1 i_clk = ~i_clk;

    euler_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
    );

    e2q_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("euler_to_quaternion test failed");
            $finish;
        end
    end

    // Receiver stalls in random bursts, none once the run turns quiet.
    always @(posedge i_clk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
            stall_left <= $urandom_range(1, 12);
        end
    end

    // Send one input beat, keeping tvalid high across back-to-back beats.
    task automatic send_angles(input logic [23:0] r, input logic [23:0] p,
                               input logic [23:0] y);
        s_tvalid <= 1'b1;
        s_tdata <= {y, p, r};
        do @(posedge i_clk); while (!s_tready);
        sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Change the unit only once every expected beat has come out.
    task automatic set_unit(input t_unit u);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= u;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 60000)) - 30000);
            2: return 24'($signed($urandom_range(0, 3000000)) - 1500000);
            default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    initial begin
        t_unit u;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part in both units: zero, extremes, quarter and half turns.
        for (int k = 0; k < 2; k++) begin
            u = t_unit'(k);
            set_unit(u);
            send_angles(24'd0, 24'd0, 24'd0);
            send_angles(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
            send_angles(24'h800000, 24'h800000, 24'h800000);
            send_angles(24'h7FFFFF, 24'h800000, 24'd0);
            send_angles(24'd12868, 24'd0, 24'd0);
            send_angles(24'd0, 24'd25736, 24'd0);
            send_angles(24'd0, 24'd0, -24'sd25736);
            send_angles(24'd737280, 24'd1474560, 24'd2949120);
            send_angles(-24'sd1474560, 24'd737280, 24'd1);
            send_angles(24'hFFFFFF, 24'd1, 24'hFFFFFF);
            send_angles(24'd51472, 24'd51472, 24'd51472);
        end

        // Random part over several unit changes.
        for (int phase = 0; phase < 5; phase++) begin
            u = (phase == 4) ? UNIT_RAD : t_unit'(phase[0]);
            set_unit(u);
            if (phase == 4) quiet = 1'b1;
            repeat (140) send_angles(rand_angle(), rand_angle(), rand_angle());
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Sent %0d angle triples in radian and degree mode, random stalls on both sides.",
                 sent);
        if (errors == 0 && pending == 0) begin
            $display("euler_to_quaternion test passed");
        end else begin
            $display("euler_to_quaternion test failed");
        end
        $finish;
    end
endmodule
